### design/ipwrb_pkg.sv
package ipwrb_pkg;

  localparam int FractionBits = 16;

  localparam int SampleW = 12;
  localparam int ErrW    = SampleW + 1;
  localparam int DiffW   = ErrW + 1;
  localparam int GainW   = 16;
  localparam int ProdW   = GainW + DiffW + 1;
  localparam int DeltaW  = ProdW + 1 - 4;
  localparam int ActionW = FractionBits;
  localparam int SumW    = ((ActionW > DeltaW) ? ActionW : DeltaW) + 2;
  localparam int BandW   = SampleW + 2;
  localparam int OutW    = 16;

  localparam logic [ActionW-1:0] ActionMax =
    ActionW'(((64'd4 << FractionBits) + 64'd2) / 64'd5);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SETPOINT = 2'd0,
    CFG_KP       = 2'd1,
    CFG_KI       = 2'd2,
    CFG_BAND     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [7:0] setpoint;
    logic [GainW-1:0]  kp;
    logic [GainW-1:0]  ki;
    logic [7:0]        band;
  } cfg_t;

  typedef struct packed {
    logic [ActionW-1:0]    action;
    logic signed [ErrW-1:0] err;
    logic                  relay_first;
    logic                  relay_second;
  } loop_state_t;

endpackage

### design/incremental_pi_with_relay_band.sv
// Path: an accepted sample goes into the input register and its result into the
// result register; the PI update and relay decision sit between the two.
// Throughput: one sample per cycle while the output is not stalled; the loop state is closed by a single register.
// Reset: asynchronous, active low; clears the loop state, both relays off,
// loads the default gains, setpoint and band, and empties both registers.
module incremental_pi_with_relay_band (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [ipwrb_pkg::SampleW-1:0]   temperature_sample_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [ipwrb_pkg::OutW-1:0]             action_level_o,
  output logic [ipwrb_pkg::OutW-1:0]             fan_drive_o,
  output logic                                   relay_first_on_o,
  output logic                                   relay_second_on_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [ipwrb_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [ipwrb_pkg::CfgDataW-1:0]         cfg_data_i
);

  ipwrb_pkg::cfg_t                         cfg;
  ipwrb_pkg::loop_state_t                  state_q;
  ipwrb_pkg::loop_state_t                  state_d;
  logic                                    in_valid_q;
  logic signed [ipwrb_pkg::SampleW-1:0]    sample_q;
  logic                                    out_valid_q;
  logic [ipwrb_pkg::ActionW-1:0]           fan_q;
  logic                                    advance;

  ipwrb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ipwrb_core u_core (
    .cfg_i    (cfg),
    .sample_i (sample_q),
    .state_i  (state_q),
    .state_o  (state_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      sample_q <= temperature_sample_i;
    end
    if (advance) begin
      fan_q <= ipwrb_pkg::ActionMax - state_d.action;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign action_level_o    = ipwrb_pkg::OutW'(state_q.action);
  assign fan_drive_o       = ipwrb_pkg::OutW'(fan_q);
  assign relay_first_on_o  = state_q.relay_first;
  assign relay_second_on_o = state_q.relay_second;

endmodule

### design/ipwrb_regs.sv
module ipwrb_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ipwrb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ipwrb_pkg::CfgDataW-1:0]  cfg_data_i,
  output ipwrb_pkg::cfg_t                 cfg_o
);

  ipwrb_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.setpoint <= 8'sd0;
      cfg_q.kp       <= 16'd13107;
      cfg_q.ki       <= 16'd590;
      cfg_q.band     <= 8'd32;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ipwrb_pkg::cfg_idx_e'(cfg_index_i))
        ipwrb_pkg::CFG_SETPOINT: cfg_q.setpoint <= $signed(cfg_data_i[7:0]);
        ipwrb_pkg::CFG_KP:       cfg_q.kp       <= cfg_data_i;
        ipwrb_pkg::CFG_KI:       cfg_q.ki       <= cfg_data_i;
        ipwrb_pkg::CFG_BAND:     cfg_q.band     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

### design/ipwrb_core.sv
module ipwrb_core (
  input  ipwrb_pkg::cfg_t                        cfg_i,
  input  logic signed [ipwrb_pkg::SampleW-1:0]   sample_i,
  input  ipwrb_pkg::loop_state_t                 state_i,
  output ipwrb_pkg::loop_state_t                 state_o
);

  logic signed [ipwrb_pkg::ErrW-1:0]    sp_ext;
  logic signed [ipwrb_pkg::ErrW-1:0]    err;
  logic signed [ipwrb_pkg::DiffW-1:0]   diff;
  logic signed [ipwrb_pkg::ProdW-1:0]   prod_p;
  logic signed [ipwrb_pkg::ProdW-1:0]   prod_i;
  logic signed [ipwrb_pkg::ProdW:0]     sum;
  logic signed [ipwrb_pkg::DeltaW-1:0]  delta;
  logic signed [ipwrb_pkg::SumW-1:0]    action_full;
  logic signed [ipwrb_pkg::BandW-1:0]   temp_ext;
  logic signed [ipwrb_pkg::BandW-1:0]   sp_band;
  logic signed [ipwrb_pkg::BandW-1:0]   band_ext;
  logic signed [ipwrb_pkg::BandW-1:0]   low;
  logic signed [ipwrb_pkg::BandW-1:0]   high;

  always_comb begin
    sp_ext = ipwrb_pkg::ErrW'($signed({cfg_i.setpoint, 4'b0000}));
    err    = ipwrb_pkg::ErrW'(sample_i) - sp_ext;
    diff   = ipwrb_pkg::DiffW'(err) - ipwrb_pkg::DiffW'(state_i.err);
    prod_p = $signed({1'b0, cfg_i.kp}) * diff;
    prod_i = $signed({1'b0, cfg_i.ki}) * err;
    sum    = (ipwrb_pkg::ProdW+1)'(prod_p) + (ipwrb_pkg::ProdW+1)'(prod_i >>> 1);
    delta  = ipwrb_pkg::DeltaW'(sum >>> 4);
    action_full = $signed(ipwrb_pkg::SumW'({1'b0, state_i.action}))
                + ipwrb_pkg::SumW'(delta);

    if (action_full > $signed(ipwrb_pkg::SumW'({1'b0, ipwrb_pkg::ActionMax}))) begin
      state_o.action = ipwrb_pkg::ActionMax;
    end else if (action_full < 0) begin
      state_o.action = '0;
    end else begin
      state_o.action = ipwrb_pkg::ActionW'(action_full);
    end
    state_o.err = err;

    temp_ext = ipwrb_pkg::BandW'(sample_i);
    sp_band  = ipwrb_pkg::BandW'(sp_ext);
    band_ext = $signed(ipwrb_pkg::BandW'({1'b0, cfg_i.band}));
    low      = sp_band - band_ext;
    high     = sp_band + band_ext;

    if (temp_ext <= low) begin
      state_o.relay_first  = 1'b1;
      state_o.relay_second = 1'b1;
    end else if (temp_ext < high) begin
      state_o.relay_first  = 1'b0;
      state_o.relay_second = 1'b1;
    end else if (temp_ext > high) begin
      state_o.relay_first  = 1'b0;
      state_o.relay_second = 1'b0;
    end else begin
      state_o.relay_first  = state_i.relay_first;
      state_o.relay_second = state_i.relay_second;
    end
  end

endmodule
